/* hdl/assert_macros.svh */
// assertion helpers for the rtl, included by rfbe_seq.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define RFBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// expression must never be true outside reset
`define RFBE_NEVER(lbl, expr, msg) \
	`RFBE_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/rfbe_pkg.sv */
package rfbe_pkg;

	// default screen geometry
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 240;

	// field widths
	localparam int PIX_W   = 16;
	localparam int COORD_W = 10;
	localparam int ALPHA_W = 9;

	// rgb565 channel layout
	localparam int RED_LSB   = 11;
	localparam int GREEN_LSB = 5;
	localparam int RB_W      = 5;
	localparam int G_W       = 6;

	// alpha of one in 1/256 units
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_BLEND = 2'd2,
		OP_FILL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_READ,
		ST_FILL
	} state_t;

	// frame store port control
	typedef struct packed {
		logic ren;
		logic wen;
		logic blend_wr;
	} mem_ctl_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

/* hdl/rfbe_ram.sv */
module rfbe_ram import rfbe_pkg::*; #(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
	localparam int AW = addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             wen,
	input  logic             ren,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[addr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/rfbe_blend.sv */
module rfbe_blend import rfbe_pkg::*; (
	input  logic [PIX_W-1:0]   old_pix,
	input  logic [PIX_W-1:0]   new_pix,
	input  logic [ALPHA_W-1:0] alpha,
	output logic [PIX_W-1:0]   mix_pix
);

	logic [ALPHA_W-1:0] inv_alpha;
	logic [15:0]        red_sum;
	logic [15:0]        green_sum;
	logic [15:0]        blue_sum;

	// complement weight, alpha is at most one here
	assign inv_alpha = ALPHA_ONE - alpha;

	// per channel weighted sum, floor by dropping the low byte
	always_comb begin
		red_sum   = 16'(old_pix[RED_LSB +: RB_W]) * 16'(inv_alpha)
			+ 16'(new_pix[RED_LSB +: RB_W]) * 16'(alpha);
		green_sum = 16'(old_pix[GREEN_LSB +: G_W]) * 16'(inv_alpha)
			+ 16'(new_pix[GREEN_LSB +: G_W]) * 16'(alpha);
		blue_sum  = 16'(old_pix[RB_W-1:0]) * 16'(inv_alpha)
			+ 16'(new_pix[RB_W-1:0]) * 16'(alpha);
		mix_pix   = {red_sum[8 +: RB_W], green_sum[8 +: G_W], blue_sum[8 +: RB_W]};
	end

endmodule

/* hdl/rfbe_seq.sv */
`include "assert_macros.svh"

module rfbe_seq import rfbe_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	localparam int AW = addr_bits(SCREEN_WIDTH * SCREEN_HEIGHT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [COORD_W-1:0] x_pos,
	input  logic [COORD_W-1:0] y_pos,
	input  logic [COORD_W-1:0] x_end,
	input  logic [COORD_W-1:0] y_end,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic [ALPHA_W-1:0] alpha,
	output mem_ctl_t           mem_ctl,
	output logic [AW-1:0]      addr,
	output logic [PIX_W-1:0]   pix_q,
	output logic [ALPHA_W-1:0] alpha_q,
	input  logic [PIX_W-1:0]   rdata,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               hit,
	output logic               done
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int PW    = AW + COORD_W + 1;
	localparam logic [COORD_W:0]   W_EXT = (COORD_W + 1)'(SCREEN_WIDTH);
	localparam logic [COORD_W:0]   H_EXT = (COORD_W + 1)'(SCREEN_HEIGHT);
	localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
	localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);
	localparam logic [PW-1:0]      W_PW  = PW'(SCREEN_WIDTH);

	state_t             state_q, state_nxt;
	op_t                op_q;
	logic [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
	logic [COORD_W-1:0] col_q, row_q, xe_c_q, ye_c_q;
	logic [AW-1:0]      row_base_q;
	logic [PIX_W-1:0]   pixel_out_q;
	logic               hit_q;
	logic               done_q;

	logic               accept;
	logic               on_screen;
	logic [PW-1:0]      prod;
	logic [AW-1:0]      pix_addr;
	logic [COORD_W-1:0] xe_clip, ye_clip;
	logic               fill_go;
	logic               blend_ok;
	logic               row_end;
	logic               fill_last;

	assign accept = start && (state_q == ST_IDLE);

	// pixel address and screen clipping from the held transaction
	always_comb begin
		on_screen = ({1'b0, x_q} < W_EXT) && ({1'b0, y_q} < H_EXT);
		prod      = PW'(y_q) * W_PW;
		pix_addr  = AW'(prod + PW'(x_q));
		xe_clip   = ({1'b0, xe_q} < W_EXT) ? xe_q : X_MAX;
		ye_clip   = ({1'b0, ye_q} < H_EXT) ? ye_q : Y_MAX;
		fill_go   = (xe_q >= x_q) && (ye_q >= y_q) && (x_q <= xe_clip) && (y_q <= ye_clip);
		blend_ok  = (alpha_q <= ALPHA_ONE) && on_screen;
		row_end   = (col_q == xe_c_q);
		fill_last = row_end && (row_q == ye_c_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				unique case (op_q)
					OP_WRITE: state_nxt = ST_IDLE;
					OP_READ:  state_nxt = ST_READ;
					OP_BLEND: state_nxt = blend_ok ? ST_READ : ST_IDLE;
					OP_FILL:  state_nxt = fill_go ? ST_FILL : ST_IDLE;
					default:  state_nxt = ST_IDLE;
				endcase
			end
			ST_READ: state_nxt = ST_IDLE;
			ST_FILL: begin
				if (fill_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		busy    = (state_q != ST_IDLE);
		mem_ctl = '0;
		addr    = pix_addr;
		unique case (state_q)
			ST_IDLE: begin
				mem_ctl = '0;
			end
			ST_ACCESS: begin
				mem_ctl.wen = (op_q == OP_WRITE) && on_screen;
				mem_ctl.ren = ((op_q == OP_READ) && on_screen) || ((op_q == OP_BLEND) && blend_ok);
			end
			ST_READ: begin
				mem_ctl.wen      = (op_q == OP_BLEND);
				mem_ctl.blend_wr = (op_q == OP_BLEND);
			end
			ST_FILL: begin
				mem_ctl.wen = 1'b1;
				addr        = AW'(row_base_q + AW'(col_q));
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// control state, fill scan position and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			pixel_out_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_READ) && (op_q == OP_READ);
			if ((state_q == ST_READ) && (op_q == OP_READ)) begin
				hit_q       <= on_screen;
				pixel_out_q <= on_screen ? rdata : '0;
			end
			if ((state_q == ST_ACCESS) && (op_q == OP_FILL)) begin
				col_q <= x_q;
				row_q <= y_q;
			end else if (state_q == ST_FILL) begin
				if (fill_last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end) begin
					col_q <= x_q;
					row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

	// transaction payload and fill bounds
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(operation);
			x_q     <= x_pos;
			y_q     <= y_pos;
			xe_q    <= x_end;
			ye_q    <= y_end;
			pix_q   <= pixel_in;
			alpha_q <= alpha;
		end
		if ((state_q == ST_ACCESS) && (op_q == OP_FILL)) begin
			xe_c_q     <= xe_clip;
			ye_c_q     <= ye_clip;
			row_base_q <= AW'(prod);
		end else if ((state_q == ST_FILL) && row_end) begin
			row_base_q <= AW'(PW'(row_base_q) + W_PW);
		end
	end

	assign pixel_out = pixel_out_q;
	assign hit       = hit_q;
	assign done      = done_q;

	`RFBE_ASSERT(a_done_after_read, done_q |-> $past(state_q == ST_READ && op_q == OP_READ), "result strobe without a read access")
	`RFBE_NEVER(a_rw_exclusive, mem_ctl.ren && mem_ctl.wen, "frame store read and write in one cycle")
	`RFBE_ASSERT(a_addr_range, (mem_ctl.ren || mem_ctl.wen) |-> (PW'(addr) < PW'(DEPTH)), "frame store access beyond the screen")
	`RFBE_ASSERT(a_blend_after_read, mem_ctl.blend_wr |-> $past(mem_ctl.ren), "blend write-back without a preceding read")
	`RFBE_ASSERT(a_fill_bounds, (state_q == ST_FILL) |-> (col_q <= xe_c_q && row_q <= ye_c_q), "fill scan outside the clipped rectangle")

endmodule

/* hdl/rgb565_framebuffer_blend_engine_top.sv */
// a read passes through the ACCESS and READ states, then drives done with its registered result
// one transaction at a time: busy stays high until the sequencer is idle again; a
//   fill writes one clipped rectangle pixel per cycle, all set by the single frame store port
// results are shown for one cycle only; the receiver cannot stall
// reset: arst_n clears the sequencer and result strobe at once; the frame store
//   is not cleared and holds undefined data until written
module rgb565_framebuffer_blend_engine_top import rfbe_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [COORD_W-1:0] x_pos,
	input  logic [COORD_W-1:0] y_pos,
	input  logic [COORD_W-1:0] x_end,
	input  logic [COORD_W-1:0] y_end,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic [ALPHA_W-1:0] alpha,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               hit,
	output logic               done
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = addr_bits(DEPTH);

	mem_ctl_t           mem_ctl;
	logic [AW-1:0]      addr;
	logic [PIX_W-1:0]   pix_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [PIX_W-1:0]   rdata;
	logic [PIX_W-1:0]   mix_pix;
	logic [PIX_W-1:0]   wdata;

	// sequencer and address generation
	rfbe_seq #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.x_end     (x_end),
		.y_end     (y_end),
		.pixel_in  (pixel_in),
		.alpha     (alpha),
		.mem_ctl   (mem_ctl),
		.addr      (addr),
		.pix_q     (pix_q),
		.alpha_q   (alpha_q),
		.rdata     (rdata),
		.pixel_out (pixel_out),
		.hit       (hit),
		.done      (done)
	);

	// channel mix of stored and new colour
	rfbe_blend u_blend (
		.old_pix (rdata),
		.new_pix (pix_q),
		.alpha   (alpha_q),
		.mix_pix (mix_pix)
	);

	// write data: blended pixel on write-back, else the transaction colour
	assign wdata = mem_ctl.blend_wr ? mix_pix : pix_q;

	// frame store
	rfbe_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.wen   (mem_ctl.wen),
		.ren   (mem_ctl.ren),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

endmodule

/* bench/tb_rgb565_framebuffer_blend_engine_top.sv */
module tb_rgb565_framebuffer_blend_engine_top;
	import rfbe_pkg::*;

	localparam int SCR_W         = SCREEN_WIDTH_DEF;
	localparam int SCR_H         = SCREEN_HEIGHT_DEF;
	localparam int RANDOM_ITEMS  = 1575;
	localparam int CALM_TAIL     = 200;
	localparam int SETTLE_CYCLES = 50;
	localparam int CYCLE_LIMIT   = 1000000;

	// one pixel transaction, or a marker that holds the sender until reads drain
	typedef struct {
		bit                 drain;
		op_t                op;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] ys;
		logic [COORD_W-1:0] xe;
		logic [COORD_W-1:0] ye;
		logic [PIX_W-1:0]   pix;
		logic [ALPHA_W-1:0] alp;
	} pixel_txn_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             hit;
	} read_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [1:0]         operation = OP_WRITE;
	logic [COORD_W-1:0] x_pos     = '0;
	logic [COORD_W-1:0] y_pos     = '0;
	logic [COORD_W-1:0] x_end     = '0;
	logic [COORD_W-1:0] y_end     = '0;
	logic [PIX_W-1:0]   pixel_in  = '0;
	logic [ALPHA_W-1:0] alpha     = '0;
	logic               busy;
	logic [PIX_W-1:0]   pixel_out;
	logic               hit;
	logic               done;

	pixel_txn_t   txn_queue[$];
	read_result_t pending_reads[$];
	logic [PIX_W-1:0] frame_copy [SCR_W*SCR_H];

	bit taken       = 1'b0;
	bit calm        = 1'b0;
	bit all_sent    = 1'b0;
	int idle_left   = 0;
	int sent_count  = 0;
	int total_items = 0;
	int failures    = 0;
	int cycles      = 0;

	rgb565_framebuffer_blend_engine_top #(
		.SCREEN_WIDTH  (SCR_W),
		.SCREEN_HEIGHT (SCR_H)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.x_end     (x_end),
		.y_end     (y_end),
		.pixel_in  (pixel_in),
		.alpha     (alpha),
		.pixel_out (pixel_out),
		.hit       (hit),
		.done      (done)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// per-channel mix of two rgb565 pixels, alpha in 1/256 units
	function automatic logic [PIX_W-1:0] mix_rgb565(input logic [PIX_W-1:0] under,
			input logic [PIX_W-1:0] over, input int a);
		int ur, ug, ub, orr, og, ob, r, g, b;
		ur  = int'(under[RED_LSB +: RB_W]);
		ug  = int'(under[GREEN_LSB +: G_W]);
		ub  = int'(under[0 +: RB_W]);
		orr = int'(over[RED_LSB +: RB_W]);
		og  = int'(over[GREEN_LSB +: G_W]);
		ob  = int'(over[0 +: RB_W]);
		r = (ur * (256 - a) + orr * a) >> 8;
		g = (ug * (256 - a) + og * a) >> 8;
		b = (ub * (256 - a) + ob * a) >> 8;
		return {r[RB_W-1:0], g[G_W-1:0], b[RB_W-1:0]};
	endfunction

	// apply one accepted transaction to the frame copy, queue the read result
	task automatic apply_pixel_op(input op_t op, input logic [COORD_W-1:0] xs,
			input logic [COORD_W-1:0] ys, input logic [COORD_W-1:0] xe,
			input logic [COORD_W-1:0] ye, input logic [PIX_W-1:0] pix,
			input logic [ALPHA_W-1:0] alp);
		int addr, col_last, row_last, r, c;
		bit on;
		read_result_t res;
		on   = (int'(xs) < SCR_W) && (int'(ys) < SCR_H);
		addr = int'(ys) * SCR_W + int'(xs);
		case (op)
			OP_WRITE: begin
				if (on)
					frame_copy[addr] = pix;
			end
			OP_READ: begin
				res.pix = on ? frame_copy[addr] : '0;
				res.hit = on;
				pending_reads.push_back(res);
			end
			OP_BLEND: begin
				if (on && alp <= ALPHA_ONE)
					frame_copy[addr] = mix_rgb565(frame_copy[addr], pix, int'(alp));
			end
			default: begin
				// empty rectangle does nothing; otherwise clip to the screen
				if (xe >= xs && ye >= ys) begin
					col_last = (int'(xe) > SCR_W - 1) ? SCR_W - 1 : int'(xe);
					row_last = (int'(ye) > SCR_H - 1) ? SCR_H - 1 : int'(ye);
					for (r = int'(ys); r <= row_last; r++)
						for (c = int'(xs); c <= col_last; c++)
							frame_copy[r * SCR_W + c] = pix;
				end
			end
		endcase
	endtask

	task automatic queue_op(input op_t op, input int xs, input int ys, input int xe,
			input int ye, input int pix, input int alp);
		pixel_txn_t t;
		t.drain = 1'b0;
		t.op    = op;
		t.xs    = COORD_W'(xs);
		t.ys    = COORD_W'(ys);
		t.xe    = COORD_W'(xe);
		t.ye    = COORD_W'(ye);
		t.pix   = PIX_W'(pix);
		t.alp   = ALPHA_W'(alp);
		txn_queue.push_back(t);
	endtask

	task automatic queue_drain();
		pixel_txn_t t;
		t.drain = 1'b1;
		txn_queue.push_back(t);
	endtask

	// coordinate biased to a small hot corner, with edges and off-screen values
	function automatic logic [COORD_W-1:0] pick_axis(input int span);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return COORD_W'($urandom_range(0, 7));
		if (roll < 85)
			return COORD_W'($urandom_range(0, span - 1));
		if (roll < 92)
			return COORD_W'($urandom_range(span - 1, span));
		return COORD_W'($urandom_range(0, 1023));
	endfunction

	// failure log, first ten reported in full
	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// monitor and predictor, sampled at the rising edge
	always @(posedge clk) begin
		read_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_reads.size() == 0) begin
					note_failure($sformatf("unexpected result pixel_out=%h hit=%b",
						pixel_out, hit));
				end else begin
					want = pending_reads.pop_front();
					if (pixel_out !== want.pix || hit !== want.hit)
						note_failure($sformatf("read mismatch: expected %h/%b, got %h/%b",
							want.pix, want.hit, pixel_out, hit));
				end
			end
			if (start && !busy)
				apply_pixel_op(op_t'(operation), x_pos, y_pos, x_end, y_end, pixel_in, alpha);
			taken <= start && !busy;
		end else begin
			taken <= 1'b0;
		end
	end

	// driver, changes inputs at the falling edge
	always @(negedge clk) begin
		pixel_txn_t nxt;
		bit send;
		send = 1'b0;
		if (arst_n) begin
			if (start && !taken) begin
				// transaction not yet accepted, hold it
				send = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (txn_queue.size() == 0) begin
				all_sent = 1'b1;
			end else if (txn_queue[0].drain) begin
				// hold off until every outstanding read has returned
				if (pending_reads.size() == 0)
					void'(txn_queue.pop_front());
			end else if (!calm && sent_count < total_items - CALM_TAIL &&
					$urandom_range(0, 3) == 0) begin
				idle_left = int'($urandom_range(0, 3));
			end else begin
				nxt = txn_queue.pop_front();
				operation <= nxt.op;
				x_pos     <= nxt.xs;
				y_pos     <= nxt.ys;
				x_end     <= nxt.xe;
				y_end     <= nxt.ye;
				pixel_in  <= nxt.pix;
				alpha     <= nxt.alp;
				send = 1'b1;
				sent_count++;
				if (sent_count % 64 == 0)
					calm = ($urandom_range(0, 1) == 1);
			end
		end
		start <= send;
	end

	// run timeout
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int n, roll;
		op_t op;
		logic [COORD_W-1:0] xs, ys, xe, ye;
		logic [PIX_W-1:0] pix;
		logic [ALPHA_W-1:0] alp;

		// directed: whole-screen fill clipped from the far corner, so every pixel is written
		queue_op(OP_FILL, 0, 0, 1023, 1023, 16'hA5A5, 0);
		queue_op(OP_READ, 0, 0, 0, 0, 0, 0);
		queue_op(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0);
		queue_op(OP_READ, SCR_W, 0, 0, 0, 0, 0);
		queue_op(OP_READ, 0, SCR_H, 0, 0, 0, 0);
		queue_op(OP_READ, 1023, 1023, 1023, 1023, 16'hFFFF, 511);
		// write at the last pixel and read it back, an off-screen write that is dropped, a clear of the origin
		queue_op(OP_WRITE, SCR_W - 1, SCR_H - 1, 0, 0, 16'hFFFF, 0);
		queue_op(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0);
		queue_op(OP_WRITE, SCR_W, 5, 0, 0, 16'h1234, 0);
		queue_op(OP_WRITE, 0, 0, 0, 0, 16'h0000, 0);
		// blends: full, zero, rejected above one, half, off screen
		queue_op(OP_BLEND, 0, 0, 0, 0, 16'hFFFF, 256);
		queue_op(OP_READ, 0, 0, 0, 0, 0, 0);
		queue_op(OP_BLEND, 0, 0, 0, 0, 16'h0000, 0);
		queue_op(OP_BLEND, 0, 0, 0, 0, 16'h0000, 511);
		queue_op(OP_BLEND, 0, 0, 0, 0, 16'h0000, 257);
		queue_op(OP_BLEND, 0, 0, 0, 0, 16'h0000, 128);
		queue_op(OP_READ, 0, 0, 0, 0, 0, 0);
		queue_op(OP_BLEND, SCR_W, SCR_H, 0, 0, 16'h0000, 128);
		// empty rectangles, partly off screen, single pixel
		queue_op(OP_FILL, 10, 10, 9, 20, 16'h1111, 0);
		queue_op(OP_FILL, 10, 10, 20, 9, 16'h2222, 0);
		queue_op(OP_FILL, SCR_W - 4, SCR_H - 4, SCR_W + 10, SCR_H + 10, 16'h07E0, 0);
		queue_op(OP_READ, SCR_W - 2, SCR_H - 2, 0, 0, 0, 0);
		queue_op(OP_FILL, 5, 5, 5, 5, 16'hF81F, 0);
		queue_op(OP_READ, 5, 5, 0, 0, 0, 0);
		// a write then a read of the same pixel
		queue_op(OP_WRITE, 7, 7, 0, 0, 16'h5555, 0);
		queue_op(OP_READ, 7, 7, 0, 0, 0, 0);
		queue_drain();

		// random transactions
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				queue_drain();
			roll = $urandom_range(0, 99);
			op = (roll < 30) ? OP_WRITE : (roll < 65) ? OP_READ :
				(roll < 90) ? OP_BLEND : OP_FILL;
			xs  = pick_axis(SCR_W);
			ys  = pick_axis(SCR_H);
			xe  = COORD_W'($urandom);
			ye  = COORD_W'($urandom);
			pix = PIX_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 65)
				alp = ALPHA_W'($urandom_range(0, 256));
			else if (roll < 72)
				alp = ALPHA_ONE;
			else if (roll < 76)
				alp = '0;
			else
				alp = ALPHA_W'($urandom_range(257, 511));
			if (op == OP_FILL) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					xe = COORD_W'(int'(xs) + int'($urandom_range(0, 7)));
					ye = COORD_W'(int'(ys) + int'($urandom_range(0, 7)));
				end else if (roll < 89) begin
					xe = COORD_W'(int'(xs) - int'($urandom_range(1, 3)));
					ye = COORD_W'(int'(ys) + int'($urandom_range(0, 3)));
				end else if (roll < 93) begin
					xe = COORD_W'(int'(xs) + int'($urandom_range(0, 3)));
					ye = COORD_W'(int'(ys) - int'($urandom_range(1, 3)));
				end else if (roll < 97) begin
					xe = COORD_W'($urandom_range(0, 1023));
					ye = COORD_W'(int'(ys) + int'($urandom_range(0, 2)));
				end else begin
					xe = COORD_W'(int'(xs) + int'($urandom_range(8, 47)));
					ye = COORD_W'(int'(ys) + int'($urandom_range(8, 47)));
				end
			end
			queue_op(op, int'(xs), int'(ys), int'(xe), int'(ye), int'(pix), int'(alp));
		end
		total_items = txn_queue.size();

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for the last transaction and its results
		wait (all_sent);
		wait (pending_reads.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_reads.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
